// ===== sv/mfr_pkg.sv =====
package mfr_pkg;

  // field widths fixed by the stream and register formats
  localparam int WORD_BITS    = 16;
  localparam int WIDTH_BITS   = 11;
  localparam int HEIGHT_BITS  = 12;
  localparam int CFG_IDX_BITS = 2;

  // result queue
  localparam int OUT_DEPTH = 16;
  localparam int PTR_W     = $clog2(OUT_DEPTH);
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_START_MIN    = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_START_MAX    = 2'd3;

  // register reset values
  localparam logic [WIDTH_BITS-1:0]  WIDTH_RST     = 11'd1024;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RST    = 12'd4095;
  localparam logic [WORD_BITS-1:0]   START_MIN_RST = 16'd0;
  localparam logic [WORD_BITS-1:0]   START_MAX_RST = 16'hFFFF;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic  action;
    word_t pixel_value;
  } in_word_t;

  typedef struct packed {
    word_t median_value;
    logic  frame_last;
    word_t running_min;
    word_t running_max;
  } out_word_t;

  // per-item control carried down the median pipeline
  typedef struct packed {
    logic emit_a;
    logic emit_b;
    logic last;
    logic seed;
  } ctl_t;

endpackage

// ===== sv/median_filter_3x3_replicate.sv =====
// 3x3 median filter with replicated borders over a raster-order pixel stream. A pixel word
// (action 0) is taken every clock while in_stall is low; it writes the two line memories (one
// read-modify-write per pixel, same-address accesses forwarded) and completes up to two
// medians, two only at a row end. After the last row, flush words (action 1) drain one median
// each; a flush is first stalled while its left column is fetched on the shared read port of
// each line memory, and is then taken. Pixels beyond the last row and flushes before it are
// taken and dropped. Results leave through a 16-entry result queue; in_stall rises while 15
// or more results are queued or in flight, so a row end of two results per pixel is
// absorbed as long as out_stall stays low. Each result carries the running minimum and maximum
// of the frame's medians, seeded from start_min and start_max at the first pixel of a frame.
// The line memories are not cleared after reset; row zero fills them before they are read.
// Registers are meant to be written between frames while no words are in flight.
module median_filter_3x3_replicate #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  mfr_pkg::in_word_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output mfr_pkg::out_word_t                 out_data,
  input  logic                               cfg_we,
  input  logic [mfr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  mfr_pkg::word_t                     cfg_wdata
);
  import mfr_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [CW-1:0]         col_idx_t;
  typedef struct packed {
    pix_t lo;
    pix_t md;
    pix_t hi;
  } col_t;

  // sorted column of three pixels
  function automatic col_t sort3(pix_t a, pix_t b, pix_t c);
    pix_t x0, x1, x2, t;
    col_t r;
    x0 = a;
    x1 = b;
    x2 = c;
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
    end
    if (x1 > x2) begin
      t = x1; x1 = x2; x2 = t;
    end
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
    end
    r.lo = x0;
    r.md = x1;
    r.hi = x2;
    return r;
  endfunction

  function automatic pix_t max3(pix_t a, pix_t b, pix_t c);
    pix_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic pix_t min3(pix_t a, pix_t b, pix_t c);
    pix_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    pix_t lo, hi, m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

  // configuration registers
  logic [WIDTH_BITS-1:0]  width_r;
  logic [HEIGHT_BITS-1:0] height_r;
  word_t                  start_min_r;
  word_t                  start_max_r;

  // frame position
  col_idx_t               col_r, col_nxt;
  logic [HEIGHT_BITS-1:0] row_r, row_nxt;
  col_idx_t               drain_r, drain_nxt;
  logic                   phase_r, phase_nxt;

  // line memories and their read ports
  pix_t     up_mem [MAX_WIDTH];
  pix_t     lo_mem [MAX_WIDTH];
  pix_t     up_rd_a_r, lo_rd_a_r, up_rd_b_r, lo_rd_b_r;
  logic     fwd_a_r, fwd_b_r;
  pix_t     fwd_up_r, fwd_lo_r;
  col_idx_t addr_a, addr_b;
  pix_t     up_a, lo_a, up_b, lo_b;

  // first stage
  logic     s1_vld_r, s1_vld_nxt;
  logic     s1_flush_r, s1_row0_r, s1_c1_r, s1_emit1_r, s1_emit2_r, s1_last_r, s1_seed_r;
  pix_t     s1_px_r, s1_clu_r, s1_cll_r;
  col_idx_t s1_ci_r;
  logic     wr_en;
  pix_t     up_wdata, lo_wdata;
  col_t     new_col, fl_l, fl_d, fl_r;
  col_t     win1_r, win2_r;

  // median pipeline
  col_t     s2_a_r [3];
  col_t     s2_b_r [3];
  col_t     s2_a_nxt [3];
  col_t     s2_b_nxt [3];
  ctl_t     s2_ctl_r, s2_ctl_nxt;
  col_t     s3_a_r, s3_b_r;
  ctl_t     s3_ctl_r;
  pix_t     s4_med_a_r, s4_med_b_r;
  ctl_t     s4_ctl_r;

  // running statistics and results
  word_t     min_r, min_nxt, max_r, max_nxt;
  word_t     m0, m1, x0, x1;
  word_t     med_a_w, med_b_w;
  out_word_t res_a, res_b, entry0;
  logic      push0, push1, pop;

  // result queue
  out_word_t        fifo_mem [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, pending_r, pending_nxt;

  // input decode
  col_idx_t               wm1, ci, d, cl, cr;
  logic [HEIGHT_BITS-1:0] hgt;
  pix_t                   pix_in;
  logic                   is_flush, frame_in, at_end, row0, c_is1, emit1, emit2, fl_last;
  logic                   need_pre, accept, live_pix, live_flush;
  logic [1:0]             n_res;

  // effective frame size
  always_comb begin
    if (width_r < WIDTH_BITS'(2)) begin
      wm1 = CW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(width_r - WIDTH_BITS'(1));
    end
    hgt = (height_r < HEIGHT_BITS'(2)) ? HEIGHT_BITS'(2) : height_r;
  end

  // item decode and handshake
  always_comb begin
    pix_in   = in_data.pixel_value[PIXEL_BITS-1:0];
    is_flush = in_data.action;
    frame_in = row_r < hgt;
    at_end   = col_r >= wm1;
    ci       = at_end ? wm1 : col_r;
    row0     = row_r == '0;
    c_is1    = col_r == CW'(1);
    emit1    = !row0 && (col_r != '0);
    emit2    = !row0 && at_end;
    fl_last  = drain_r >= wm1;
    d        = fl_last ? wm1 : drain_r;
    cl       = (d == '0) ? '0 : d - CW'(1);
    cr       = (d < wm1) ? d + CW'(1) : wm1;

    need_pre   = in_valid && is_flush && !frame_in && !phase_r;
    in_stall   = (pending_r > CNT_W'(OUT_DEPTH - 2)) || need_pre;
    accept     = in_valid && !in_stall;
    live_pix   = accept && !is_flush && frame_in;
    live_flush = accept && is_flush && !frame_in;
    phase_nxt  = need_pre || (phase_r && in_valid && in_stall);

    if (live_pix) begin
      n_res = {1'b0, emit1} + {1'b0, emit2};
    end else if (live_flush) begin
      n_res = 2'd1;
    end else begin
      n_res = 2'd0;
    end
    s1_vld_nxt = live_pix || live_flush;

    // port a: left column before a flush, center column on it, pixel column otherwise
    if (is_flush) begin
      addr_a = accept ? d : cl;
    end else begin
      addr_a = ci;
    end
    addr_b = cr;
  end

  // position counters
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    drain_nxt = drain_r;
    if (live_pix) begin
      if (at_end) begin
        col_nxt = '0;
        row_nxt = row_r + HEIGHT_BITS'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end else if (live_flush) begin
      if (fl_last) begin
        drain_nxt = '0;
        row_nxt   = '0;
        col_nxt   = '0;
      end else begin
        drain_nxt = drain_r + CW'(1);
      end
    end
  end

  // line memories: one write, two registered reads, same-cycle write forwarded
  always_ff @(posedge clk) begin
    if (wr_en) begin
      up_mem[s1_ci_r] <= up_wdata;
      lo_mem[s1_ci_r] <= lo_wdata;
    end
    up_rd_a_r <= up_mem[addr_a];
    lo_rd_a_r <= lo_mem[addr_a];
    up_rd_b_r <= up_mem[addr_b];
    lo_rd_b_r <= lo_mem[addr_b];
    fwd_a_r   <= wr_en && (s1_ci_r == addr_a);
    fwd_b_r   <= wr_en && (s1_ci_r == addr_b);
    fwd_up_r  <= up_wdata;
    fwd_lo_r  <= lo_wdata;
  end

  always_comb begin
    up_a = fwd_a_r ? fwd_up_r : up_rd_a_r;
    lo_a = fwd_a_r ? fwd_lo_r : lo_rd_a_r;
    up_b = fwd_b_r ? fwd_up_r : up_rd_b_r;
    lo_b = fwd_b_r ? fwd_lo_r : lo_rd_b_r;
  end

  // first stage: write back, sort incoming columns, pick lane columns
  always_comb begin
    wr_en    = s1_vld_r && !s1_flush_r;
    up_wdata = s1_row0_r ? s1_px_r : lo_a;
    lo_wdata = s1_px_r;
    new_col  = sort3(s1_row0_r ? s1_px_r : up_a, s1_row0_r ? s1_px_r : lo_a, s1_px_r);
    fl_l     = sort3(s1_clu_r, s1_cll_r, s1_cll_r);
    fl_d     = sort3(up_a, lo_a, lo_a);
    fl_r     = sort3(up_b, lo_b, lo_b);

    if (s1_flush_r) begin
      s2_a_nxt[0] = fl_l;
      s2_a_nxt[1] = fl_d;
      s2_a_nxt[2] = fl_r;
    end else begin
      s2_a_nxt[0] = s1_c1_r ? win2_r : win1_r;
      s2_a_nxt[1] = win2_r;
      s2_a_nxt[2] = new_col;
    end
    s2_b_nxt[0] = win2_r;
    s2_b_nxt[1] = new_col;
    s2_b_nxt[2] = new_col;

    s2_ctl_nxt = '0;
    if (s1_vld_r) begin
      if (s1_flush_r) begin
        s2_ctl_nxt.emit_a = 1'b1;
        s2_ctl_nxt.last   = s1_last_r;
      end else begin
        s2_ctl_nxt.emit_a = s1_emit1_r;
        s2_ctl_nxt.emit_b = s1_emit2_r;
        s2_ctl_nxt.seed   = s1_seed_r;
      end
    end
  end

  // datapath registers of the pipeline
  always_ff @(posedge clk) begin
    s1_flush_r <= is_flush;
    s1_px_r    <= pix_in;
    s1_ci_r    <= ci;
    s1_row0_r  <= row0;
    s1_c1_r    <= c_is1;
    s1_emit1_r <= emit1;
    s1_emit2_r <= emit2;
    s1_last_r  <= fl_last;
    s1_seed_r  <= row0 && (col_r == '0);
    s1_clu_r   <= up_a;
    s1_cll_r   <= lo_a;

    if (wr_en) begin
      win1_r <= win2_r;
      win2_r <= new_col;
    end

    s2_a_r <= s2_a_nxt;
    s2_b_r <= s2_b_nxt;

    // max of lows, median of middles, min of highs
    s3_a_r.lo <= max3(s2_a_r[0].lo, s2_a_r[1].lo, s2_a_r[2].lo);
    s3_a_r.md <= med3(s2_a_r[0].md, s2_a_r[1].md, s2_a_r[2].md);
    s3_a_r.hi <= min3(s2_a_r[0].hi, s2_a_r[1].hi, s2_a_r[2].hi);
    s3_b_r.lo <= max3(s2_b_r[0].lo, s2_b_r[1].lo, s2_b_r[2].lo);
    s3_b_r.md <= med3(s2_b_r[0].md, s2_b_r[1].md, s2_b_r[2].md);
    s3_b_r.hi <= min3(s2_b_r[0].hi, s2_b_r[1].hi, s2_b_r[2].hi);

    s4_med_a_r <= med3(s3_a_r.lo, s3_a_r.md, s3_a_r.hi);
    s4_med_b_r <= med3(s3_b_r.lo, s3_b_r.md, s3_b_r.hi);
  end

  // running min and max, lane a before lane b
  always_comb begin
    m0      = s4_ctl_r.seed ? start_min_r : min_r;
    x0      = s4_ctl_r.seed ? start_max_r : max_r;
    med_a_w = WORD_BITS'(s4_med_a_r);
    med_b_w = WORD_BITS'(s4_med_b_r);

    m1 = m0;
    x1 = x0;
    if (s4_ctl_r.emit_a) begin
      if (med_a_w < m0) begin
        m1 = med_a_w;
      end else if (med_a_w > x0) begin
        x1 = med_a_w;
      end
    end
    min_nxt = m1;
    max_nxt = x1;
    if (s4_ctl_r.emit_b) begin
      if (med_b_w < m1) begin
        min_nxt = med_b_w;
      end else if (med_b_w > x1) begin
        max_nxt = med_b_w;
      end
    end

    res_a.median_value = med_a_w;
    res_a.frame_last   = s4_ctl_r.last;
    res_a.running_min  = m1;
    res_a.running_max  = x1;
    res_b.median_value = med_b_w;
    res_b.frame_last   = 1'b0;
    res_b.running_min  = min_nxt;
    res_b.running_max  = max_nxt;

    push0  = s4_ctl_r.emit_a || s4_ctl_r.emit_b;
    push1  = s4_ctl_r.emit_a && s4_ctl_r.emit_b;
    entry0 = s4_ctl_r.emit_a ? res_a : res_b;
  end

  // result queue and in-flight count
  always_comb begin
    out_valid   = cnt_r != '0;
    out_data    = fifo_mem[rd_ptr_r];
    pop         = out_valid && !out_stall;
    wr_ptr_nxt  = wr_ptr_r + PTR_W'(push0) + PTR_W'(push1);
    rd_ptr_nxt  = rd_ptr_r + PTR_W'(pop);
    cnt_nxt     = cnt_r + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);
    pending_nxt = pending_r + CNT_W'(n_res) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      fifo_mem[wr_ptr_r] <= entry0;
    end
    if (push1) begin
      fifo_mem[wr_ptr_r + PTR_W'(1)] <= res_b;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
      start_min_r <= START_MIN_RST;
      start_max_r <= START_MAX_RST;
      col_r       <= '0;
      row_r       <= '0;
      drain_r     <= '0;
      phase_r     <= 1'b0;
      s1_vld_r    <= 1'b0;
      s2_ctl_r    <= '0;
      s3_ctl_r    <= '0;
      s4_ctl_r    <= '0;
      min_r       <= START_MIN_RST;
      max_r       <= START_MAX_RST;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
      pending_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  width_r     <= cfg_wdata[WIDTH_BITS-1:0];
          CFG_IMAGE_HEIGHT: height_r    <= cfg_wdata[HEIGHT_BITS-1:0];
          CFG_START_MIN:    start_min_r <= cfg_wdata;
          CFG_START_MAX:    start_max_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      drain_r   <= drain_nxt;
      phase_r   <= phase_nxt;
      s1_vld_r  <= s1_vld_nxt;
      s2_ctl_r  <= s2_ctl_nxt;
      s3_ctl_r  <= s2_ctl_r;
      s4_ctl_r  <= s3_ctl_r;
      min_r     <= min_nxt;
      max_r     <= max_nxt;
      wr_ptr_r  <= wr_ptr_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      cnt_r     <= cnt_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule

// ===== dv/median_filter_3x3_replicate_tb.sv =====
module median_filter_3x3_replicate_tb;
  import mfr_pkg::*;

  localparam int  LINE_DEPTH  = 1024;
  localparam int  STALL_LIMIT = 2000;
  localparam int  DRAIN_WAIT  = 12;
  localparam logic ACT_PIXEL  = 1'b0;
  localparam logic ACT_FLUSH  = 1'b1;

  typedef logic [8:0][WORD_BITS-1:0] nine_t;
  typedef enum int {PIX_NOISE, PIX_RAILS, PIX_BAND, PIX_STEPS} pix_style_t;

  // mirror of the filter: line stores, window, counters and running extremes
  class median_tracker;
    int unsigned width_reg, height_reg;
    word_t       seed_min, seed_max;
    word_t       upper [LINE_DEPTH];
    word_t       lower [LINE_DEPTH];
    nine_t       win;
    logic [9:0]  col;
    logic [11:0] row;
    logic [10:0] drain;
    word_t       run_min, run_max;
    out_word_t   pending_medians[$];
    int          fails;

    function new();
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      seed_min   = START_MIN_RST;
      seed_max   = START_MAX_RST;
      win        = '0;
      col        = '0;
      row        = '0;
      drain      = '0;
      run_min    = 16'h0000;
      run_max    = 16'hFFFF;
      fails      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, word_t val);
      case (idx)
        CFG_IMAGE_WIDTH:  width_reg  = val[WIDTH_BITS-1:0];
        CFG_IMAGE_HEIGHT: height_reg = val[HEIGHT_BITS-1:0];
        CFG_START_MIN:    seed_min   = val;
        CFG_START_MAX:    seed_max   = val;
        default: ;
      endcase
    endfunction

    function int unsigned span_w();
      if (width_reg < 2) return 2;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
    endfunction

    function int unsigned span_h();
      return (height_reg < 2) ? 2 : height_reg;
    endfunction

    // 5th smallest of nine by insertion sort
    function word_t mid_of_nine(nine_t v);
      word_t t;
      int    i, j;
      for (i = 1; i < 9; i++) begin
        t = v[i];
        j = i;
        while (j > 0 && v[j-1] > t) begin
          v[j] = v[j-1];
          j--;
        end
        v[j] = t;
      end
      return v[4];
    endfunction

    // neighbourhood built from window columns l, m, r
    function word_t window_mid(int l, int m, int r);
      nine_t v;
      int    k;
      for (k = 0; k < 3; k++) begin
        v[k*3+0] = win[k*3+l];
        v[k*3+1] = win[k*3+m];
        v[k*3+2] = win[k*3+r];
      end
      return mid_of_nine(v);
    endfunction

    function void post(word_t med, logic last);
      out_word_t r;
      if (med < run_min) run_min = med;
      else if (med > run_max) run_max = med;
      r.median_value = med;
      r.frame_last   = last;
      r.running_min  = run_min;
      r.running_max  = run_max;
      pending_medians.push_back(r);
    endfunction

    // accepted input word: advance state, queue the medians it completes
    function void take_word(in_word_t w);
      int unsigned wd, ht, c, ci, d, cl, cr, k;
      word_t       px;
      nine_t       v;
      logic        last;
      wd = span_w();
      ht = span_h();
      px = w.pixel_value;
      if (w.action == ACT_PIXEL) begin
        c  = col;
        ci = (c < wd) ? c : wd - 1;
        if (row >= ht) return;
        if (row == 0 && c == 0) begin
          run_min = seed_min;
          run_max = seed_max;
        end
        if (row == 0) begin
          upper[ci] = px;
          lower[ci] = px;
        end
        for (k = 0; k < 3; k++) begin
          win[k*3+0] = win[k*3+1];
          win[k*3+1] = win[k*3+2];
        end
        win[2] = upper[ci];
        win[5] = lower[ci];
        win[8] = px;
        if (row > 0) begin
          upper[ci] = lower[ci];
          lower[ci] = px;
        end
        if (row > 0 && c >= 1)
          post((c == 1) ? window_mid(1, 1, 2) : window_mid(0, 1, 2), 1'b0);
        if (c >= wd - 1) begin
          if (row > 0) post(window_mid(1, 2, 2), 1'b0);
          col = '0;
          row = row + 1'b1;
        end else begin
          col = 10'(c + 1);
        end
      end else begin
        if (row < ht) return;
        d  = (drain < wd) ? drain : wd - 1;
        cl = (d > 0) ? d - 1 : 0;
        cr = (d + 1 < wd) ? d + 1 : wd - 1;
        // bottom row replicates the last row
        v[0] = upper[cl]; v[1] = upper[d]; v[2] = upper[cr];
        v[3] = lower[cl]; v[4] = lower[d]; v[5] = lower[cr];
        v[6] = v[3];      v[7] = v[4];     v[8] = v[5];
        last = (drain >= wd - 1);
        post(mid_of_nine(v), last);
        if (last) begin
          drain = '0;
          row   = '0;
          col   = '0;
        end else begin
          drain = drain + 1'b1;
        end
      end
    endfunction

    // accepted result word against the oldest pending median
    function void match_median(out_word_t got);
      out_word_t want;
      if (pending_medians.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected result: med %h last %b min %h max %h",
                   got.median_value, got.frame_last, got.running_min, got.running_max);
        return;
      end
      want = pending_medians.pop_front();
      if (got.median_value !== want.median_value || got.frame_last !== want.frame_last ||
          got.running_min !== want.running_min || got.running_max !== want.running_max) begin
        fails++;
        if (fails <= 10)
          $display("mismatch: expected med %h last %b min %h max %h, got med %h last %b min %h max %h",
                   want.median_value, want.frame_last, want.running_min, want.running_max,
                   got.median_value, got.frame_last, got.running_min, got.running_max);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  logic      cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  word_t     cfg_wdata = '0;

  median_tracker trk = new();
  logic      calm = 1'b0;
  int        words_sent = 0;
  int        stuck_cycles = 0;

  median_filter_3x3_replicate dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // result side back-pressure
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 29);
  end

  // monitor: register writes, accepted words, watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) trk.set_reg(cfg_index, cfg_wdata);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
      else stuck_cycles++;
      if (in_valid && !in_stall) trk.take_word(in_data);
      if (out_valid && !out_stall) trk.match_median(out_data);
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic word_t pick_pixel(pix_style_t s, word_t base);
    case (s)
      PIX_RAILS: return ($urandom_range(7) == 0) ? word_t'($urandom) :
                        ($urandom_range(1) ? 16'hFFFF : 16'h0000);
      PIX_BAND:  return base + word_t'($urandom_range(3));
      PIX_STEPS: return word_t'($urandom_range(3) * 16'h5555);
      default:   return word_t'($urandom);
    endcase
  endfunction

  function automatic word_t pick_seed();
    case ($urandom_range(3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return word_t'($urandom);
    endcase
  endfunction

  // one word on the input channel, held until taken; called at a falling edge
  task automatic send_word(input logic act, input word_t v);
    in_word_t w;
    w.action      = act;
    w.pixel_value = v;
    if (!calm)
      while ($urandom_range(99) < 29) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
    @(negedge clk);
  endtask

  // drop valid and wait until every pending median is out and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (trk.pending_medians.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // write all four registers on consecutive cycles
  task automatic set_frame(input word_t w, input word_t h, input word_t lo, input word_t hi);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_wdata <= h;
    @(negedge clk);
    cfg_index <= CFG_START_MIN;
    cfg_wdata <= lo;
    @(negedge clk);
    cfg_index <= CFG_START_MAX;
    cfg_wdata <= hi;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // whole frame of w x h pixels plus the drain; noisy adds ignored words
  task automatic run_frame(input int w, input int h, input pix_style_t s, input bit noisy);
    int    r, c;
    word_t base;
    base = word_t'($urandom);
    for (r = 0; r < h; r++)
      for (c = 0; c < w; c++) begin
        if (noisy && $urandom_range(99) < 3) send_word(ACT_FLUSH, word_t'($urandom));
        send_word(ACT_PIXEL, pick_pixel(s, base));
      end
    if (noisy) repeat ($urandom_range(2)) send_word(ACT_PIXEL, word_t'($urandom));
    for (c = 0; c < w; c++) send_word(ACT_FLUSH, word_t'($urandom));
  endtask

  initial begin
    int    start, wd, ht, r;
    word_t wreg, hreg;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // smallest frame, seeds reversed, early flush and a pixel past the last row
    set_frame(16'd2, 16'd2, 16'hFFFF, 16'h0000);
    send_word(ACT_FLUSH, 16'hFFFF);
    send_word(ACT_PIXEL, 16'h0000);
    send_word(ACT_PIXEL, 16'hFFFF);
    send_word(ACT_PIXEL, 16'hFFFF);
    send_word(ACT_PIXEL, 16'h0000);
    send_word(ACT_PIXEL, 16'h5A5A);
    send_word(ACT_FLUSH, 16'h0000);
    send_word(ACT_FLUSH, 16'hA5A5);
    settle();

    // pixel extremes on a 3 x 2 frame
    set_frame(16'd3, 16'd2, 16'h0000, 16'hFFFF);
    send_word(ACT_PIXEL, 16'hFFFF);
    send_word(ACT_PIXEL, 16'h0000);
    send_word(ACT_PIXEL, 16'h8001);
    send_word(ACT_PIXEL, 16'h7FFE);
    send_word(ACT_PIXEL, 16'hFFFF);
    send_word(ACT_PIXEL, 16'h0001);
    repeat (3) send_word(ACT_FLUSH, word_t'($urandom));
    settle();

    // size narrowed inside a frame: width mid-row, then height after row two
    set_frame(16'd4, 16'd4, 16'h1234, 16'h4321);
    repeat (6) send_word(ACT_PIXEL, word_t'($urandom));
    settle();
    set_frame(16'd3, 16'd4, 16'h1234, 16'h4321);
    repeat (4) send_word(ACT_PIXEL, word_t'($urandom));
    settle();
    set_frame(16'd3, 16'd3, 16'h1234, 16'h4321);
    repeat (3) send_word(ACT_FLUSH, word_t'($urandom));
    settle();

    // size extremes: tallest setting and zero width, then cut down to three rows
    set_frame(16'd0, 16'd4095, pick_seed(), pick_seed());
    repeat (6) send_word(ACT_PIXEL, pick_pixel(PIX_RAILS, 16'h0000));
    settle();
    set_frame(16'd0, 16'd3, pick_seed(), pick_seed());
    repeat (2) send_word(ACT_FLUSH, word_t'($urandom));
    settle();

    // widest setting with back-to-back words, narrowed before the row ends
    calm = 1'b1;
    set_frame(16'd2047, 16'd2, pick_seed(), pick_seed());
    repeat (40) send_word(ACT_PIXEL, word_t'($urandom));
    settle();
    set_frame(16'd41, 16'd2, pick_seed(), pick_seed());
    repeat (42) send_word(ACT_PIXEL, word_t'($urandom));
    repeat (41) send_word(ACT_FLUSH, word_t'($urandom));
    calm = 1'b0;
    settle();

    // random frames, mostly small, sometimes back to back on the same setting
    start = words_sent;
    wd = 4;
    ht = 3;
    while (words_sent - start < 1390) begin
      if ($urandom_range(3) != 0) begin
        r  = $urandom_range(99);
        wd = (r < 80) ? $urandom_range(8, 2) : (r < 95) ? $urandom_range(40, 9) :
             $urandom_range(130, 41);
        ht = ($urandom_range(99) < 85) ? $urandom_range(6, 2) : $urandom_range(16, 7);
        wreg = word_t'(wd);
        hreg = word_t'(ht);
        if (wd == 2 && $urandom_range(1)) wreg = word_t'($urandom_range(1));
        if (ht == 2 && $urandom_range(1)) hreg = word_t'($urandom_range(1));
        settle();
        set_frame(wreg, hreg, pick_seed(), pick_seed());
      end
      calm = (words_sent - start >= 500) && (words_sent - start < 800);
      run_frame(wd, ht, pix_style_t'($urandom_range(3)), $urandom_range(3) == 0);
    end
    calm = 1'b0;

    // drain and report
    in_valid <= 1'b0;
    while (trk.pending_medians.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (trk.fails == 0 && trk.pending_medians.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/mfr_pkg.sv
sv/median_filter_3x3_replicate.sv
dv/median_filter_3x3_replicate_tb.sv
